// ===== sv/frustum_plane_extraction_defines.svh =====
// Assertion macros for the checker file of the frustum plane block.
// No dependencies.
`ifndef FRUSTUM_PLANE_EXTRACTION_DEFINES_SVH
`define FRUSTUM_PLANE_EXTRACTION_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/fpe_pkg.sv =====
// Package for the frustum plane block: widths, plane codes, queue record, back states.
// No dependencies.
package fpe_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumPlanes   = 6;
  localparam int unsigned SumW        = 33;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [2:0] {
    PL_LEFT   = 3'd0,
    PL_RIGHT  = 3'd1,
    PL_TOP    = 3'd2,
    PL_BOTTOM = 3'd3,
    PL_NEAR   = 3'd4,
    PL_FAR    = 3'd5
  } plane_e;

  // One plane handed from front to back: its index and its four sums.
  typedef struct packed {
    logic [2:0]             idx;
    logic signed [SumW-1:0] a;
    logic signed [SumW-1:0] b;
    logic signed [SumW-1:0] c;
    logic signed [SumW-1:0] d;
  } plane_req_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SQ, BK_SQRT, BK_DIV, BK_OUT
  } back_state_e;
endpackage

// ===== sv/frustum_plane_extraction.sv =====
// Top level of the frustum plane block: front, queue and back.
// Depends on fpe_pkg, fpe_front, fpe_queue, fpe_back.
//  channel | direction | handshake             | payload
//  col     | in        | col_valid_i/col_stall_o | col_x/y/z/w
//  plane   | out       | plane_valid_o/plane_stall_i | index, a..d, flags
// Columns 0..2 are accepted without stall; column 3 blocks the front until its six
// planes are in the queue. The back takes one plane at a time, with a single
// bit-serial root unit and divider; a zero normal skips the divides.
// Reset clears counters and valid flags; a stalled output holds its plane.
module frustum_plane_extraction import fpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               col_valid_i,
  output logic               col_stall_o,
  input  logic signed [31:0] col_x_i,
  input  logic signed [31:0] col_y_i,
  input  logic signed [31:0] col_z_i,
  input  logic signed [31:0] col_w_i,
  output logic               plane_valid_o,
  input  logic               plane_stall_i,
  output logic [2:0]         plane_index_o,
  output logic signed [31:0] plane_a_o,
  output logic signed [31:0] plane_b_o,
  output logic signed [31:0] plane_c_o,
  output logic signed [31:0] plane_d_o,
  output logic               degenerate_o,
  output logic               last_plane_o
);
  logic f_v, f_s, b_v, b_s;
  plane_req_t f_r, b_r;

  fpe_front u_front (
    .clk_i, .rst_ni, .col_valid_i, .col_stall_o,
    .col_x_i, .col_y_i, .col_z_i, .col_w_i,
    .q_valid_o(f_v), .q_stall_i(f_s), .q_req_o(f_r)
  );

  fpe_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_v), .in_stall_o(f_s), .in_req_i(f_r),
    .out_valid_o(b_v), .out_stall_i(b_s), .out_req_o(b_r)
  );

  fpe_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_v), .q_stall_o(b_s), .q_req_i(b_r),
    .plane_valid_o, .plane_stall_i, .plane_index_o,
    .plane_a_o, .plane_b_o, .plane_c_o, .plane_d_o,
    .degenerate_o, .last_plane_o
  );
endmodule

// ===== sv/fpe_front.sv =====
// Front end: takes columns, forms the six plane sums, releases planes.
// Depends on fpe_pkg.
module fpe_front import fpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               col_valid_i,
  output logic               col_stall_o,
  input  logic signed [31:0] col_x_i,
  input  logic signed [31:0] col_y_i,
  input  logic signed [31:0] col_z_i,
  input  logic signed [31:0] col_w_i,
  output logic               q_valid_o,
  input  logic               q_stall_i,
  output plane_req_t         q_req_o
);
  logic [1:0] col_q, col_d;
  logic       emit_q, emit_d;
  logic [2:0] pl_q, pl_d;
  logic signed [SumW-1:0] sums_q [NumPlanes][4];
  logic signed [SumW-1:0] x, y, z, w;
  logic acc;

  assign x = SumW'(col_x_i);
  assign y = SumW'(col_y_i);
  assign z = SumW'(col_z_i);
  assign w = SumW'(col_w_i);
  assign col_stall_o = emit_q;
  assign acc = col_valid_i && !emit_q;

  // Sum store, one column per request.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      sums_q[PL_LEFT][col_q]   <= w + x;
      sums_q[PL_RIGHT][col_q]  <= w - x;
      sums_q[PL_TOP][col_q]    <= w - y;
      sums_q[PL_BOTTOM][col_q] <= w + y;
      sums_q[PL_NEAR][col_q]   <= w + z;
      sums_q[PL_FAR][col_q]    <= w - z;
    end
  end

  // Column counter and plane release.
  always_comb begin
    col_d  = col_q;
    emit_d = emit_q;
    pl_d   = pl_q;
    if (acc) begin
      col_d = col_q + 2'd1;
      if (col_q == 2'd3) begin
        emit_d = 1'b1;
        pl_d   = 3'd0;
      end
    end
    if (emit_q && !q_stall_i) begin
      pl_d = pl_q + 3'd1;
      if (pl_q == 3'(NumPlanes - 1)) emit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      emit_q <= 1'b0;
      pl_q   <= '0;
    end else begin
      col_q  <= col_d;
      emit_q <= emit_d;
      pl_q   <= pl_d;
    end
  end

  assign q_valid_o  = emit_q;
  assign q_req_o.idx = pl_q;
  assign q_req_o.a  = sums_q[pl_q][0];
  assign q_req_o.b  = sums_q[pl_q][1];
  assign q_req_o.c  = sums_q[pl_q][2];
  assign q_req_o.d  = sums_q[pl_q][3];
endmodule

// ===== sv/fpe_queue.sv =====
// Short queue of plane records between front and back.
// Depends on fpe_pkg.
module fpe_queue import fpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  plane_req_t in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output plane_req_t out_req_o
);
  plane_req_t mem_q [QueueDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_stall_o  = (cnt_q == 2'(QueueDepth));
  assign out_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;
  assign out_req_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== sv/fpe_back.sv =====
// Back end: squared length, bit-serial root, restoring divides, output reg.
// Depends on fpe_pkg.
module fpe_back import fpe_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_stall_o,
  input  plane_req_t         q_req_i,
  output logic               plane_valid_o,
  input  logic               plane_stall_i,
  output logic [2:0]         plane_index_o,
  output logic signed [31:0] plane_a_o,
  output logic signed [31:0] plane_b_o,
  output logic signed [31:0] plane_c_o,
  output logic signed [31:0] plane_d_o,
  output logic               degenerate_o,
  output logic               last_plane_o
);
  localparam int unsigned NumW = SumW + FRAC_BITS;  // dividend width
  localparam int unsigned SqW  = 68;

  back_state_e st_q, st_d;
  plane_req_t  r_q;
  logic [SqW-1:0] s_q;
  logic [1:0]  sq_q;
  logic [34:0] root_q;
  logic [5:0]  bit_q;
  logic [1:0]  dsel_q;
  logic [6:0]  dstep_q;
  logic [NumW-1:0] num_q, quo_q;
  logic [35:0] drem_q;
  logic signed [31:0] res_q [4];
  logic out_v_q;

  logic [SumW-1:0] mag_sel;
  logic [65:0] sqr;
  logic [34:0] trial;
  logic [69:0] trial_sq;
  logic [36:0] drem_sh;
  logic signed [SumW-1:0] vsel;

  assign q_stall_o = (st_q != BK_IDLE);

  always_comb begin
    case (sq_q)
      2'd0:    vsel = r_q.a;
      2'd1:    vsel = r_q.b;
      default: vsel = r_q.c;
    endcase
    if (st_q == BK_DIV || st_q == BK_OUT) begin
      case (dsel_q)
        2'd0:    vsel = r_q.a;
        2'd1:    vsel = r_q.b;
        2'd2:    vsel = r_q.c;
        default: vsel = r_q.d;
      endcase
    end
    mag_sel  = vsel[SumW-1] ? SumW'(-vsel) : SumW'(vsel);
    sqr      = 66'(mag_sel) * 66'(mag_sel);
    trial    = root_q | (35'd1 << bit_q);
    trial_sq = 70'(trial) * 70'(trial);
    drem_sh  = {drem_q, num_q[NumW-1]};
  end

  // Sequencer: three squares, 35 root steps, four divides of NumW steps unless the root is zero.
  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: if (q_valid_i) st_d = BK_SQ;
      BK_SQ:   if (sq_q == 2'd2) st_d = BK_SQRT;
      BK_SQRT: if (bit_q == 6'd0) st_d = (root_q == '0 && trial_sq > 70'(s_q)) ?
                                         BK_OUT : BK_DIV;
      BK_DIV:  if (dsel_q == 2'd3 && dstep_q == 7'(NumW)) st_d = BK_OUT;
      BK_OUT:  if (!out_v_q || !plane_stall_i) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else         st_q <= st_d;
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (st_q)
      BK_IDLE: begin
        r_q <= q_req_i; s_q <= '0; sq_q <= '0;
        root_q <= '0; bit_q <= 6'd34; dsel_q <= '0; dstep_q <= '0;
      end
      BK_SQ: begin
        s_q  <= s_q + SqW'(sqr);
        sq_q <= sq_q + 2'd1;
      end
      BK_SQRT: begin
        if (trial_sq <= 70'(s_q)) root_q <= trial;
        if (bit_q != 6'd0) bit_q <= bit_q - 6'd1;
      end
      BK_DIV: begin
        if (dstep_q == 7'd0) begin
          num_q   <= NumW'(mag_sel) << FRAC_BITS;
          drem_q  <= '0;
          quo_q   <= '0;
          dstep_q <= 7'd1;
        end else if (dstep_q <= 7'(NumW)) begin
          if (drem_sh >= 37'(root_q)) begin
            drem_q <= 36'(drem_sh - 37'(root_q));
            quo_q  <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            drem_q <= drem_sh[35:0];
            quo_q  <= {quo_q[NumW-2:0], 1'b0};
          end
          num_q <= num_q << 1;
          if (dstep_q == 7'(NumW)) begin
            dstep_q <= 7'd0;
            dsel_q  <= dsel_q + 2'd1;
          end else begin
            dstep_q <= dstep_q + 7'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Saturating sign restore of a finished quotient.
  logic [NumW-1:0] qfin;
  logic signed [31:0] sat;
  assign qfin = (drem_sh >= 37'(root_q)) ? {quo_q[NumW-2:0], 1'b1}
                                         : {quo_q[NumW-2:0], 1'b0};
  always_comb begin
    if (vsel[SumW-1]) sat = (qfin > NumW'(33'h080000000)) ? 32'sh80000000
                                                           : 32'(-qfin);
    else              sat = (qfin > NumW'(32'h7fffffff)) ? 32'sh7fffffff : 32'(qfin);
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE) begin
      res_q[0] <= '0; res_q[1] <= '0; res_q[2] <= '0; res_q[3] <= '0;
    end else if (st_q == BK_DIV && dstep_q == 7'(NumW)) begin
      res_q[dsel_q] <= sat;
    end
  end

  // Output register, loaded when the plane is done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (st_q == BK_OUT && (!out_v_q || !plane_stall_i)) out_v_q <= 1'b1;
    else if (!plane_stall_i) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_OUT && (!out_v_q || !plane_stall_i)) begin
      plane_index_o <= r_q.idx;
      plane_a_o     <= res_q[0];
      plane_b_o     <= res_q[1];
      plane_c_o     <= res_q[2];
      plane_d_o     <= res_q[3];
      degenerate_o  <= (root_q == '0);
      last_plane_o  <= (r_q.idx == PL_FAR);
    end
  end

  assign plane_valid_o = out_v_q;
endmodule

// ===== sv/fpe_checker.sv =====
// Port-level checker for the frustum plane block, bound to the top level.
// Depends on fpe_pkg and frustum_plane_extraction_defines.svh.
`include "frustum_plane_extraction_defines.svh"
module fpe_checker import fpe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        plane_valid_o,
  input logic        plane_stall_i,
  input logic [2:0]  plane_index_o,
  input logic        degenerate_o,
  input logic        last_plane_o,
  input logic signed [31:0] plane_a_o
);
  `FPE_ASSERT_IMP(a_idx_range, clk_i, rst_ni, plane_valid_o, plane_index_o <= PL_FAR)
  `FPE_ASSERT_IMP(a_last_far, clk_i, rst_ni, plane_valid_o,
                  last_plane_o == (plane_index_o == PL_FAR))
  `FPE_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, plane_valid_o && degenerate_o, plane_a_o == 32'sd0)
  `FPE_ASSERT_NXT(a_hold, clk_i, rst_ni, plane_valid_o && plane_stall_i,
                  plane_valid_o && $stable(plane_index_o))
endmodule

bind frustum_plane_extraction fpe_checker u_fpe_checker (
  .clk_i, .rst_ni, .plane_valid_o, .plane_stall_i, .plane_index_o,
  .degenerate_o, .last_plane_o, .plane_a_o
);

// ===== tb/sv/tb.sv =====
// Testbench for frustum_plane_extraction: drives matrix columns, predicts the six
// normalized planes per matrix and checks every plane request against them.
// Depends on fpe_pkg and the frustum_plane_extraction RTL.
module tb;
  import fpe_pkg::*;

  localparam int unsigned FracBits  = FracBitsDef;
  localparam int          WatchLim  = 20000;
  localparam int          NumRandMx = 80;

  // Expected plane record
  typedef struct {
    logic [2:0]         idx;
    logic signed [31:0] a, b, c, d;
    logic               degen, last;
  } plane_exp_t;

  // Scoreboard: holds column sums and the queue of expected planes
  class plane_board;
    logic signed [32:0] sums [6][4];
    int                 col_cnt;
    plane_exp_t         pend[$];
    int                 fails;

    function new();
      col_cnt = 0;
      fails   = 0;
    endfunction

    // Truncating divide of a sum by the normal length, saturated to 32 bits
    function logic signed [31:0] norm_val(logic signed [32:0] v, logic [63:0] len);
      logic [127:0] mg;
      logic [127:0] q;
      begin
        mg = 128'(v);
        if (v < 0) mg = -mg;
        q  = (mg << FracBits) / len;
        if (v < 0) begin
          if (q > 128'h8000_0000) q = 128'h8000_0000;
          norm_val = 32'(-q);
        end else begin
          if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
          norm_val = 32'(q);
        end
      end
    endfunction

    // Note an accepted column request
    function void note_column(logic signed [31:0] x, y, z, w);
      logic [127:0] s, t, mk;
      logic [63:0]  r;
      plane_exp_t   e;
      begin
        sums[0][col_cnt] = 33'(w) + 33'(x);
        sums[1][col_cnt] = 33'(w) - 33'(x);
        sums[2][col_cnt] = 33'(w) - 33'(y);
        sums[3][col_cnt] = 33'(w) + 33'(y);
        sums[4][col_cnt] = 33'(w) + 33'(z);
        sums[5][col_cnt] = 33'(w) - 33'(z);
        if (col_cnt == 3) begin
          for (int p = 0; p < 6; p++) begin
            s = 0;
            for (int k = 0; k < 3; k++) begin
              mk = 128'(sums[p][k]);
              if (sums[p][k] < 0) mk = -mk;
              s += mk * mk;
            end
            r = 0;
            for (int bt = 34; bt >= 0; bt--) begin
              t = 128'(r | (64'd1 << bt));
              if (t * t <= s) r = r | (64'd1 << bt);
            end
            e.idx  = 3'(p);
            e.last = (p == 5);
            if (r == 0) begin
              e.a = 0; e.b = 0; e.c = 0; e.d = 0; e.degen = 1'b1;
            end else begin
              e.a = norm_val(sums[p][0], r);
              e.b = norm_val(sums[p][1], r);
              e.c = norm_val(sums[p][2], r);
              e.d = norm_val(sums[p][3], r);
              e.degen = 1'b0;
            end
            pend.push_back(e);
          end
        end
        col_cnt = (col_cnt + 1) % 4;
      end
    endfunction

    // Check an accepted plane request against the oldest expectation
    function void check_plane(logic [2:0] idx, logic signed [31:0] a, b, c, d,
                              logic degen, logic last);
      plane_exp_t e;
      begin
        if (pend.size() == 0) begin
          $error("unexpected plane request, index %0d", idx);
          fails++;
        end else begin
          e = pend.pop_front();
          if (idx !== e.idx) begin
            $error("plane_index exp %0d got %0d", e.idx, idx); fails++; end
          if (a !== e.a) begin $error("plane_a exp %0d got %0d", e.a, a); fails++; end
          if (b !== e.b) begin $error("plane_b exp %0d got %0d", e.b, b); fails++; end
          if (c !== e.c) begin $error("plane_c exp %0d got %0d", e.c, c); fails++; end
          if (d !== e.d) begin $error("plane_d exp %0d got %0d", e.d, d); fails++; end
          if (degen !== e.degen) begin
            $error("degenerate exp %0d got %0d", e.degen, degen); fails++; end
          if (last !== e.last) begin
            $error("last_plane exp %0d got %0d", e.last, last); fails++; end
        end
      end
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               col_valid_i, col_stall_o;
  logic signed [31:0] col_x_i, col_y_i, col_z_i, col_w_i;
  logic               plane_valid_o, plane_stall_i;
  logic [2:0]         plane_index_o;
  logic signed [31:0] plane_a_o, plane_b_o, plane_c_o, plane_d_o;
  logic               degenerate_o, last_plane_o;

  plane_board board;
  bit         quiet;
  int         idle_cnt;
  bit         fail_flag;

  frustum_plane_extraction #(.FRAC_BITS(FracBits)) uut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Random 32-bit value biased toward extremes and small values
  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: pick_val = 32'sh7FFF_FFFF;
      1: pick_val = 32'sh8000_0000;
      2: pick_val = 32'(signed'($urandom_range(0, 1 << 18)) - (1 << 17));
      3: pick_val = 0;
      default: pick_val = $urandom;
    endcase
  endfunction

  // Send one column request; valid held until accepted
  task automatic send_col(logic signed [31:0] x, y, z, w);
    int gap;
    begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
        col_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      col_valid_i <= 1'b1;
      col_x_i <= x; col_y_i <= y; col_z_i <= z; col_w_i <= w;
      do @(posedge clk_i); while (col_stall_o);
      @(negedge clk_i);
    end
  endtask

  task automatic send_matrix(bit rnd, logic signed [31:0] m[16]);
    for (int j = 0; j < 4; j++) begin
      if (rnd) send_col(pick_val(), pick_val(), pick_val(), pick_val());
      else     send_col(m[j*4], m[j*4+1], m[j*4+2], m[j*4+3]);
    end
  endtask

  // Accept side: random stall bursts, checks at rising edge
  initial begin
    plane_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        plane_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
      plane_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && plane_valid_o && !plane_stall_i)
      board.check_plane(plane_index_o, plane_a_o, plane_b_o, plane_c_o, plane_d_o,
                        degenerate_o, last_plane_o);
  end

  // Watchdog on cycles without any accepted request
  always @(posedge clk_i) begin
    if (!rst_ni || (col_valid_i && !col_stall_o) || (plane_valid_o && !plane_stall_i))
      idle_cnt <= 0;
    else if (idle_cnt >= WatchLim) begin
      $display("Simulation FAILED");
      $finish;
    end else idle_cnt <= idle_cnt + 1;
  end

  // Note accepted columns
  always @(posedge clk_i) begin
    if (rst_ni && col_valid_i && !col_stall_o)
      board.note_column(col_x_i, col_y_i, col_z_i, col_w_i);
  end

  // Stimulus
  initial begin
    logic signed [31:0] m[16];
    board = new();
    quiet = 1'b0;
    rst_ni = 1'b0;
    col_valid_i = 1'b0;
    col_x_i = 0; col_y_i = 0; col_z_i = 0; col_w_i = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Identity-like matrix, scaled by one in fixed point
    foreach (m[i]) m[i] = (i % 5 == 0) ? 32'sd1 <<< FracBits : 0;
    send_matrix(0, m);
    // All zero: every plane has a zero normal
    foreach (m[i]) m[i] = 0;
    send_matrix(0, m);
    // Extremes: tiny normal with huge offset saturates d
    foreach (m[i]) m[i] = 0;
    m[0] = 1; m[12] = 32'sh7FFF_FFFF; m[13] = 32'sh7FFF_FFFF;
    m[14] = 32'sh8000_0000; m[15] = 32'sh8000_0000;
    send_matrix(0, m);
    // Largest magnitudes everywhere
    foreach (m[i]) m[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    send_matrix(0, m);
    foreach (m[i]) m[i] = 32'sh8000_0000;
    send_matrix(0, m);
    foreach (m[i]) m[i] = -1;
    send_matrix(0, m);

    // Random matrices, quiet at the end
    for (int n = 0; n < NumRandMx; n++) begin
      if (n == NumRandMx - 10) quiet = 1'b1;
      send_matrix(1, m);
    end
    col_valid_i <= 1'b0;

    while (board.pend.size() != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
    fail_flag = (board.fails != 0) || (board.pend.size() != 0);
    if (!fail_flag) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
